@@ sv/hbe_pkg.sv @@
// Shared types and constants for the hash-to-braid-word encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package hbe_pkg;

  // Upper bound on the strand count after saturation.
  localparam logic [3:0] MaxStrands = 4'd15;
  localparam logic [3:0] MinStrands = 4'd2;

  // Configuration register map (word index = paddr[4:2]).
  localparam int unsigned AddrWidth = 5;
  localparam logic [2:0] RegStrands  = 3'd0;
  localparam logic [2:0] RegGenCode0 = 3'd1;
  localparam logic [2:0] RegGenCode1 = 3'd2;
  localparam logic [2:0] RegGenCode2 = 3'd3;
  localparam logic [2:0] RegGenCode3 = 3'd4;

  localparam logic [3:0] StrandsRst  = 4'd8;
  localparam logic [3:0] GenCode0Rst = 4'd1;
  localparam logic [3:0] GenCode1Rst = 4'd3;
  localparam logic [3:0] GenCode2Rst = 4'd5;
  localparam logic [3:0] GenCode3Rst = 4'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MID,
    ST_CONN,
    ST_FSETUP,
    ST_FMID,
    ST_SUFFIX
  } hbe_state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic take_in;     // latch request byte, select high nibble
    logic setup;       // decode nibble, load run counters
    logic emit_mid;    // emit held generator, count down repeats
    logic emit_j;      // emit +/- j and step j
    logic commit;      // nibble done: update held state
    logic fin_setup;   // load final middle and suffix
    logic final_phase; // tail of the word, word_end may fire
    logic finish;      // return to message-start state
  } hbe_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic at_start;
    logic reps_one;
    logic j_at_lim;
    logic nib_lo;
    logic last;
    logic out_free;
  } hbe_status_t;

  typedef logic [3:0] gen_t;

endpackage
`default_nettype wire

@@ sv/hbe_regs.sv @@
// APB-style configuration registers: strand count and four generator codes.
// Depends on hbe_pkg.
`default_nettype none
module hbe_regs
  import hbe_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output gen_t                      strands_o,
  output gen_t                      gen_code_o [4]
);

  gen_t       strands_q;
  gen_t       gen_q [4];
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrWidth-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strands_q <= StrandsRst;
      gen_q[0]  <= GenCode0Rst;
      gen_q[1]  <= GenCode1Rst;
      gen_q[2]  <= GenCode2Rst;
      gen_q[3]  <= GenCode3Rst;
    end else if (wr_en) begin
      case (idx)
        RegStrands:  strands_q <= pwdata[3:0];
        RegGenCode0: gen_q[0]  <= pwdata[3:0];
        RegGenCode1: gen_q[1]  <= pwdata[3:0];
        RegGenCode2: gen_q[2]  <= pwdata[3:0];
        RegGenCode3: gen_q[3]  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegStrands:  prdata = {28'd0, strands_q};
      RegGenCode0: prdata = {28'd0, gen_q[0]};
      RegGenCode1: prdata = {28'd0, gen_q[1]};
      RegGenCode2: prdata = {28'd0, gen_q[2]};
      RegGenCode3: prdata = {28'd0, gen_q[3]};
      default:     prdata = 32'd0;
    endcase
  end

  assign strands_o  = strands_q;
  assign gen_code_o = gen_q;

endmodule
`default_nettype wire

@@ sv/hbe_ctrl.sv @@
// Sequencing state machine: walks prefix, middle, connector and suffix runs.
// Depends on hbe_pkg.
`default_nettype none
module hbe_ctrl
  import hbe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  hbe_status_t      status_i,
  output hbe_cmd_t         cmd_o
);

  hbe_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = status_i.at_start ? ST_CONN : ST_MID;
      end
      ST_MID: begin
        if (status_i.out_free && status_i.reps_one) state_d = ST_CONN;
      end
      ST_CONN: begin
        if (status_i.j_at_lim) begin
          if (!status_i.nib_lo)    state_d = ST_SETUP;
          else if (status_i.last)  state_d = ST_FSETUP;
          else                     state_d = ST_IDLE;
        end
      end
      ST_FSETUP: begin
        state_d = ST_FMID;
      end
      ST_FMID: begin
        if (status_i.out_free && status_i.reps_one) state_d = ST_SUFFIX;
      end
      ST_SUFFIX: begin
        if (status_i.j_at_lim) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.take_in = in_valid_i;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      ST_MID: begin
        cmd_o.emit_mid = status_i.out_free;
      end
      ST_CONN: begin
        cmd_o.commit = status_i.j_at_lim;
        cmd_o.emit_j = !status_i.j_at_lim && status_i.out_free;
      end
      ST_FSETUP: begin
        cmd_o.fin_setup = 1'b1;
      end
      ST_FMID: begin
        cmd_o.final_phase = 1'b1;
        cmd_o.emit_mid    = status_i.out_free;
      end
      ST_SUFFIX: begin
        cmd_o.final_phase = 1'b1;
        cmd_o.finish      = status_i.j_at_lim;
        cmd_o.emit_j      = !status_i.j_at_lim && status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/hbe_dp.sv @@
// Datapath: nibble decode, run counters, held message state, output register.
// Depends on hbe_pkg.
`default_nettype none
module hbe_dp
  import hbe_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         final_byte_i,
  input  gen_t              strands_i,
  input  gen_t              gen_code_i [4],
  input  hbe_cmd_t          cmd_i,
  output hbe_status_t       status_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic signed [4:0] artin_gen_o,
  output logic              word_end_o
);

  // request latch
  logic [7:0] byte_q;
  logic       last_q;
  logic       nib_lo_q;

  // held message state
  gen_t       held_gen_q;
  logic [2:0] held_pow_q;
  logic       skip_q;
  logic       at_start_q;

  // current nibble and run counters
  gen_t       cur_g_q;
  logic [2:0] cur_p_q;
  gen_t       j_q, lim_q;
  logic       asc_q;
  logic [3:0] reps_q;

  // output register
  logic              out_valid_q;
  logic signed [4:0] gen_q;
  logic              end_q;

  gen_t       n_eff, g_raw, g_eff, nm1;
  logic [3:0] nib;
  logic [3:0] reps_new;
  logic [4:0] j_ext;
  logic       emit;

  // strand count saturated, generator clamped into 1..n-1
  always_comb begin
    n_eff = (strands_i < MinStrands) ? MinStrands : strands_i;
    if (n_eff > MaxStrands) n_eff = MaxStrands;
    nm1   = n_eff - 4'd1;
    nib   = nib_lo_q ? byte_q[3:0] : byte_q[7:4];
    g_raw = gen_code_i[nib[1:0]];
    g_eff = (g_raw > nm1) ? nm1 : g_raw;
    if (g_eff == 4'd0) g_eff = 4'd1;
  end

  assign reps_new = {held_pow_q, 1'b0} - {3'd0, skip_q};
  assign j_ext    = {1'b0, j_q};
  assign emit     = cmd_i.emit_mid || cmd_i.emit_j;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_gen_q <= '0;
      held_pow_q <= '0;
      skip_q     <= 1'b0;
      at_start_q <= 1'b1;
      nib_lo_q   <= 1'b0;
    end else begin
      if (cmd_i.take_in) nib_lo_q <= 1'b0;
      if (cmd_i.commit) begin
        held_gen_q <= cur_g_q;
        held_pow_q <= cur_p_q;
        skip_q     <= asc_q;
        at_start_q <= 1'b0;
        nib_lo_q   <= 1'b1;
      end
      if (cmd_i.finish) begin
        held_gen_q <= '0;
        held_pow_q <= '0;
        skip_q     <= 1'b0;
        at_start_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      byte_q <= data_byte_i;
      last_q <= final_byte_i;
    end
    if (cmd_i.setup) begin
      cur_g_q <= g_eff;
      cur_p_q <= {1'b0, nib[3:2]} + 3'd1;
      lim_q   <= g_eff;
      reps_q  <= reps_new;
      if (at_start_q) begin
        j_q   <= nm1;
        asc_q <= 1'b0;
      end else if (held_gen_q >= g_eff) begin
        j_q   <= held_gen_q;
        asc_q <= 1'b0;
      end else begin
        j_q   <= held_gen_q + 4'd1;
        asc_q <= 1'b1;
      end
    end
    if (cmd_i.fin_setup) begin
      reps_q <= reps_new;
      j_q    <= held_gen_q + 4'd1;
      lim_q  <= n_eff;
      asc_q  <= 1'b1;
    end
    if (cmd_i.emit_mid) reps_q <= reps_q - 4'd1;
    if (cmd_i.emit_j)   j_q    <= asc_q ? j_q + 4'd1 : j_q - 4'd1;
  end

  // output stage: loads whenever empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_mid) begin
      gen_q <= $signed({1'b0, held_gen_q});
      end_q <= cmd_i.final_phase && (reps_q == 4'd1) && (j_q == lim_q);
    end else if (cmd_i.emit_j) begin
      gen_q <= asc_q ? $signed(5'd0 - j_ext) : $signed(j_ext);
      end_q <= cmd_i.final_phase && ((j_ext + 5'd1) == {1'b0, lim_q});
    end
  end

  assign status_o.at_start = at_start_q;
  assign status_o.reps_one = (reps_q == 4'd1);
  assign status_o.j_at_lim = (j_q == lim_q);
  assign status_o.nib_lo   = nib_lo_q;
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign artin_gen_o = gen_q;
  assign word_end_o  = end_q;

endmodule
`default_nettype wire

@@ sv/hash_to_braid_word_encoder.sv @@
// Top level of the hash-to-braid-word encoder: registers, controller, datapath.
// Depends on hbe_pkg, hbe_regs, hbe_ctrl and hbe_dp.
//
// Usage
//   Input channel: one request per message byte (data_byte_i, final_byte_i),
//   taken when in_valid_i is high and in_stall_o is low. in_stall_o is low
//   only while the sequencer is idle, so one byte is worked on at a time.
//   Output channel: one signed Artin generator per transfer; word_end_o marks
//   the last generator of the whole word on the final byte.
//   Sequencing: a byte is first accepted, then each nibble takes a decode
//   step, middle repeats (2*p, less one after an ascending connector; none
//   on the first nibble of a message), the connector or prefix run and a
//   commit step. The final byte adds a final setup step, the final middle
//   and the suffix run. The output register takes one generator per cycle
//   while out_stall_i does not hold it, so the sequencer's emission runs
//   set how fast bytes are worked through.
//   Back-pressure: while out_stall_i is high a valid output register holds and
//   the sequencer waits on its next emission; nothing is dropped.
//   Reset: configuration returns to strands 8 and generators 1, 3, 5, 7, and
//   the next byte opens a new message. Configuration is to be written over
//   the APB-style port only while the block is idle; it is not enforced.
`default_nettype none
module hash_to_braid_word_encoder
  import hbe_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 final_byte_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [4:0]         artin_gen_o,
  output logic                      word_end_o,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

  gen_t        strands;
  gen_t        gen_code [4];
  hbe_cmd_t    cmd;
  hbe_status_t status;

  hbe_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .strands_o  (strands),
    .gen_code_o (gen_code)
  );

  // sequencer: decides which run is being emitted
  hbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counters, held generator/power and the output register
  hbe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .strands_i    (strands),
    .gen_code_i   (gen_code),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .artin_gen_o  (artin_gen_o),
    .word_end_o   (word_end_o)
  );

endmodule
`default_nettype wire

@@ sv/hbe_checker.sv @@
// Port-level checks for the hash-to-braid-word encoder, bound to the top level.
// Depends on hbe_pkg and hash_to_braid_word_encoder.
`default_nettype none
module hbe_checker
  import hbe_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic signed [4:0] artin_gen_o
  ,
  input wire logic              word_end_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(artin_gen_o)
      && $stable(word_end_o))
    else $error("stalled result changed");

  // one byte at a time: busy right after a request is taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // generators lie in -14..-1, 1..14
  a_gen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> artin_gen_o != 5'sd0 && artin_gen_o != 5'sd15
      && artin_gen_o != -5'sd15 && artin_gen_o != -5'sd16)
    else $error("generator out of range");

endmodule

bind hash_to_braid_word_encoder hbe_checker u_hbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .artin_gen_o (artin_gen_o),
  .word_end_o  (word_end_o)
);
`default_nettype wire
